>>> sv/nfir_pkg.sv
`default_nettype none
package nfir_pkg;

   localparam int DATA_W     = 16;
   localparam int FRAC_SHIFT = 14;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_TAPS_BEHIND = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAPS_AHEAD  = 4'd1;

   localparam logic FUNC_COEF   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic shift;
      logic rotate;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic start;
      logic accum;
      logic take;
   } mac_ctl_type;

endpackage
`default_nettype wire

>>> sv/nfir_cell.sv
`default_nettype none
module nfir_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  nfir_pkg::cell_ctl_type  ctl,
   input  nfir_pkg::data_type      prev_sample,
   input  nfir_pkg::data_type      next_sample,
   input  nfir_pkg::data_type      next_coef,
   input  wire                     coef_we,
   input  nfir_pkg::data_type      coef_value,
   output nfir_pkg::data_type      sample_out,
   output nfir_pkg::data_type      coef_out
);

   nfir_pkg::data_type sample_ff, sample_in;
   nfir_pkg::data_type coef_ff, coef_in;

   always_comb begin
      if (ctl.clear) begin
         sample_in = '0;
      end else if (ctl.shift) begin
         sample_in = prev_sample;
      end else if (ctl.rotate) begin
         sample_in = next_sample;
      end else begin
         sample_in = sample_ff;
      end

      if (coef_we) begin
         coef_in = coef_value;
      end else if (ctl.rotate) begin
         coef_in = next_coef;
      end else begin
         coef_in = coef_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   assign sample_out = sample_ff;
   assign coef_out   = coef_ff;

endmodule
`default_nettype wire

>>> sv/nfir_mac.sv
`default_nettype none
module nfir_mac #(
   parameter int TAPS = 64
) (
   input  wire                    clock,
   input  nfir_pkg::mac_ctl_type  ctl,
   input  nfir_pkg::data_type     sample,
   input  nfir_pkg::data_type     coef,
   output nfir_pkg::data_type     filtered
);

   localparam int ACC_W  = 32 + $clog2(TAPS);
   localparam int PROD_W = 2 * nfir_pkg::DATA_W;

   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (nfir_pkg::FRAC_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [ACC_W-1:0]  quot;

   always_comb begin
      prod_in = ctl.take ? (PROD_W'(sample) * PROD_W'(coef)) : '0;
      if (ctl.start) begin
         acc_in = '0;
      end else if (ctl.accum) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, floor shift, saturate to Q1.15
   always_comb begin
      rounded = acc_ff + HALF;
      quot    = rounded >>> nfir_pkg::FRAC_SHIFT;
      if (quot > SAT_HI) begin
         filtered = nfir_pkg::DATA_W'(SAT_HI);
      end else if (quot < SAT_LO) begin
         filtered = nfir_pkg::DATA_W'(SAT_LO);
      end else begin
         filtered = quot[nfir_pkg::DATA_W-1:0];
      end
   end

endmodule
`default_nettype wire

>>> sv/noncausal_fir_filter.sv
`default_nettype none
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid/req_tready     tdata: coef_index, coef_value, sample;
//                                               tuser: func; tlast: last
// rsp      out        rsp_tvalid/rsp_tready     tdata: filtered; tlast: last_out
// csr      in         csr_valid/csr_ready       csr_index, csr_data
//
// After a coefficient write or a sample that owes no output, the block stays idle.
// A sample that produces an output holds off requests while the tap chain rotates
// once past the single multiply-accumulate unit, then the sum drains and rounds.
// A last sample adds a shift per leading zero, a shift and full pass per flushed
// output, and clears the delay line. Reset is synchronous; all taps reset to zero.
// A full output register stalls the block only when the next result is ready.
module noncausal_fir_filter #(
   parameter int TAPS      = 64,
   parameter int MAX_AHEAD = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [39:0]                         req_tdata,  // coef_index[5:0], coef_value[21:6], sample[37:22]
   input  wire                                 req_tuser,  // func
   input  wire                                 req_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [15:0]                         rsp_tdata,  // filtered[15:0]
   output logic                                rsp_tlast,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [nfir_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [nfir_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ROT_W = $clog2(TAPS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LEAD  = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_MAC   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [3:0]       pend_ff, pend_in;
   logic [3:0]       lead_ff, lead_in;
   logic [3:0]       left_ff, left_in;
   logic [ROT_W-1:0] rot_ff, rot_in;
   logic             fin_ff, fin_in;
   logic             flush_ff, flush_in;
   logic             last_flag_ff, last_flag_in;
   logic [5:0]       taps_behind_ff;
   logic [3:0]       taps_ahead_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;
   logic             rsp_last_ff;
   logic             rsp_load;

   logic [9:0]       ahead_wide;
   logic [3:0]       ahead;
   logic [5:0]       behind;
   logic [9:0]       win_sum;
   logic [9:0]       win_len;
   logic [3:0]       p_calc;
   logic [3:0]       lead_calc;

   logic             req_accept;
   logic             req_func;
   logic [5:0]       req_coef_index;
   nfir_pkg::data_type req_coef_value;
   nfir_pkg::data_type req_sample;

   nfir_pkg::cell_ctl_type cell_ctl;
   nfir_pkg::mac_ctl_type  mac_ctl;
   nfir_pkg::data_type     head_sample;
   logic                   coef_wr;
   nfir_pkg::data_type     filtered;

   nfir_pkg::data_type     cell_sample [TAPS];
   nfir_pkg::data_type     cell_coef   [TAPS];

   function automatic logic [2:0] flush_state(input logic [3:0] lead, input logic [3:0] left);
      logic [2:0] st;
      if (lead != 4'd0) begin
         st = S_LEAD;
      end else if (left != 4'd0) begin
         st = S_ZERO;
      end else begin
         st = S_CLEAR;
      end
      return st;
   endfunction

   assign req_func       = req_tuser;
   assign req_coef_index = req_tdata[5:0];
   assign req_coef_value = req_tdata[21:6];
   assign req_sample     = req_tdata[37:22];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // effective window
   always_comb begin
      ahead_wide = 10'(taps_ahead_ff);
      if (ahead_wide > 10'(MAX_AHEAD)) begin
         ahead_wide = 10'(MAX_AHEAD);
      end
      if (ahead_wide > 10'(TAPS - 1)) begin
         ahead_wide = 10'(TAPS - 1);
      end
      ahead   = ahead_wide[3:0];
      behind  = (taps_behind_ff == 6'd0) ? 6'd1 : taps_behind_ff;
      win_sum = 10'(ahead) + 10'(behind);
      win_len = (win_sum > 10'(TAPS)) ? 10'(TAPS) : win_sum;
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      lead_in      = lead_ff;
      left_in      = left_ff;
      rot_in       = rot_ff;
      fin_in       = fin_ff;
      flush_in     = flush_ff;
      last_flag_in = last_flag_ff;
      cell_ctl     = '0;
      mac_ctl      = '0;
      head_sample  = '0;
      coef_wr      = 1'b0;
      rsp_load     = 1'b0;
      p_calc       = pend_ff;
      lead_calc    = 4'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_func == nfir_pkg::FUNC_COEF) begin
                  coef_wr = 1'b1;
               end else begin
                  cell_ctl.shift = 1'b1;
                  head_sample    = req_sample;
                  fin_in         = req_tlast;
                  rot_in         = '0;
                  if (pend_ff >= ahead) begin
                     p_calc       = pend_ff;
                     last_flag_in = req_tlast && (pend_ff == 4'd0);
                     flush_in     = 1'b0;
                     state_in     = S_MAC;
                  end else begin
                     p_calc  = pend_ff + 4'd1;
                     pend_in = p_calc;
                  end
                  lead_calc = (p_calc < ahead) ? (ahead - p_calc) : 4'd0;
                  lead_in   = lead_calc;
                  left_in   = p_calc;
                  if ((pend_ff < ahead) && req_tlast) begin
                     flush_in = 1'b1;
                     state_in = flush_state(lead_calc, p_calc);
                  end
               end
            end
         end
         S_LEAD: begin
            cell_ctl.shift = 1'b1;
            lead_in        = lead_ff - 4'd1;
            if (lead_ff == 4'd1) begin
               state_in = (left_ff != 4'd0) ? S_ZERO : S_CLEAR;
            end
         end
         S_ZERO: begin
            cell_ctl.shift = 1'b1;
            left_in        = left_ff - 4'd1;
            last_flag_in   = (left_ff == 4'd1);
            rot_in         = '0;
            state_in       = S_MAC;
         end
         S_MAC: begin
            cell_ctl.rotate = 1'b1;
            mac_ctl.take    = (10'(rot_ff) < win_len);
            mac_ctl.start   = (rot_ff == '0);
            mac_ctl.accum   = (rot_ff != '0);
            rot_in          = rot_ff + ROT_W'(1);
            if (rot_ff == ROT_W'(TAPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            mac_ctl.accum = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               if (flush_ff) begin
                  state_in = (left_ff != 4'd0) ? S_ZERO : S_CLEAR;
               end else if (fin_ff) begin
                  flush_in = 1'b1;
                  state_in = flush_state(lead_ff, left_ff);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLEAR: begin
            cell_ctl.clear = 1'b1;
            pend_in        = 4'd0;
            flush_in       = 1'b0;
            fin_in         = 1'b0;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pend_ff        <= 4'd0;
         fin_ff         <= 1'b0;
         flush_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         taps_behind_ff <= 6'd1;
         taps_ahead_ff  <= 4'd0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         fin_ff       <= fin_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == nfir_pkg::REG_TAPS_BEHIND) begin
               taps_behind_ff <= csr_data[5:0];
            end else if (csr_index == nfir_pkg::REG_TAPS_AHEAD) begin
               taps_ahead_ff <= csr_data[3:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lead_ff      <= lead_in;
      left_ff      <= left_in;
      rot_ff       <= rot_in;
      last_flag_ff <= last_flag_in;
      if (rsp_load) begin
         rsp_data_ff <= filtered;
         rsp_last_ff <= last_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // tap chain: shifts toward higher taps on a new sample or a flush zero, rotates toward tap 0
   // during the multiply-accumulate pass
   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      nfir_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .prev_sample ((k == 0) ? head_sample : cell_sample[(k + TAPS - 1) % TAPS]),
         .next_sample (cell_sample[(k + 1) % TAPS]),
         .next_coef   (cell_coef[(k + 1) % TAPS]),
         .coef_we     (coef_wr && (10'(req_coef_index) == 10'(k))),
         .coef_value  (req_coef_value),
         .sample_out  (cell_sample[k]),
         .coef_out    (cell_coef[k])
      );
   end

   nfir_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock    (clock),
      .ctl      (mac_ctl),
      .sample   (cell_sample[0]),
      .coef     (cell_coef[0]),
      .filtered (filtered)
   );

endmodule
`default_nettype wire
